// File: design/antenna_pattern_response_core_macros.svh
// ----------------------------------------------------------------------------
// antenna pattern response assertion macros
// concurrent check helpers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ANTENNA_PATTERN_RESPONSE_CORE_MACROS_SVH
`define ANTENNA_PATTERN_RESPONSE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define APR_CHECK_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apr check failed");
// next-cycle implication
`define APR_CHECK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apr check failed");
`else
`define APR_CHECK_NOW(label, clk, rst, ante, cons)
`define APR_CHECK_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: design/apr_pkg.sv
// ----------------------------------------------------------------------------
// apr_pkg
// shared constants, types and helpers of the antenna pattern response core
// ----------------------------------------------------------------------------
package apr_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int IN_W     = 16;
  localparam int OUT_W    = 18;
  localparam int REG_W    = 18;
  localparam int NUM_REGS = 6;
  localparam int IDX_W    = 3;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_XX    = 3'd0,
    REG_YY    = 3'd1,
    REG_ZZ    = 3'd2,
    REG_XY    = 3'd3,
    REG_XZ    = 3'd4,
    REG_YZ    = 3'd5
  } reg_idx_t;

  // round(2 pi * 2^29)
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [31:0] Q30_ONE    = 32'h4000_0000;

  // taylor series divisors, innermost first, with floor(2^32 / d)
  localparam int HORNER_STEPS = 5;
  localparam logic [6:0] HORNER_DEN [HORNER_STEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [31:0] HORNER_RECIP [HORNER_STEPS] = '{
    32'(64'd4294967296 / 64'd110),
    32'(64'd4294967296 / 64'd72),
    32'(64'd4294967296 / 64'd42),
    32'(64'd4294967296 / 64'd20),
    32'(64'd4294967296 / 64'd6)
  };

  // pipeline depths
  localparam int HORNER_LAT = 3;
  localparam int SIN_LAT    = 4 + HORNER_STEPS * HORNER_LAT;
  localparam int CONTR_LAT  = 6;
  localparam int ROT_LAT    = 3;
  localparam int TOTAL_LAT  = SIN_LAT + CONTR_LAT + ROT_LAT;

  // sine kernel state carried through one horner step
  typedef struct packed {
    logic [30:0] x;
    logic [31:0] x2;
    logic [30:0] y;
    logic        neg;
  } kern_t;

  localparam logic signed [63:0] SAT_HI = 64'sd131071;
  localparam logic signed [63:0] SAT_LO = -64'sd131072;

  // clamp to the signed output range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SAT_HI) begin
      r = OUT_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = OUT_W'(SAT_LO);
    end else begin
      r = OUT_W'(v);
    end
    return r;
  endfunction

endpackage

// File: design/apr_in_if.sv
// ----------------------------------------------------------------------------
// apr_in_if
// sky direction and polarization channel, valid/ready
// ----------------------------------------------------------------------------
interface apr_in_if;
  import apr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [IN_W-1:0]        right_ascension;
  logic signed [IN_W-1:0] declination;
  logic [IN_W-1:0]        pol_angle;

  modport source(output valid, right_ascension, declination, pol_angle, input ready);
  modport sink(input valid, right_ascension, declination, pol_angle, output ready);
endinterface

// File: design/apr_out_if.sv
// ----------------------------------------------------------------------------
// apr_out_if
// antenna response channel, valid/ready
// ----------------------------------------------------------------------------
interface apr_out_if;
  import apr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] plus_response;
  logic signed [OUT_W-1:0] cross_response;
  logic signed [OUT_W-1:0] plus_contraction;
  logic signed [OUT_W-1:0] cross_contraction;

  modport source(output valid, plus_response, cross_response, plus_contraction,
                 cross_contraction, input ready);
  modport sink(input valid, plus_response, cross_response, plus_contraction,
               cross_contraction, output ready);
endinterface

// File: design/antenna_pattern_response_core.sv
// ----------------------------------------------------------------------------
// antenna_pattern_response_core
// detector plus and cross response for a sky direction and polarization
// ----------------------------------------------------------------------------
//  channel     dir  handshake     payload
//  direction   in   valid/ready   right_ascension, declination, pol_angle
//  response    out  valid/ready   plus/cross_response, plus/cross_contraction
//  write port  in   write_en      write_index, write_data
//
//  one item per clock while the pipeline advances; in order the stages are the six
//  sine pipelines, then vectors, basis tensors and contraction, then the rotation
//  the whole pipeline advances when the output register is empty or taken
//  reset clears valid bits and the tensor registers, no clearing pass
// ----------------------------------------------------------------------------
`include "antenna_pattern_response_core_macros.svh"

module antenna_pattern_response_core #(
  parameter int ANGLE_BITS = apr_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = apr_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  apr_in_if.sink                    direction,
  apr_out_if.source                 response,
  input  logic                      write_en,
  input  logic [apr_pkg::IDX_W-1:0] write_index,
  input  logic [apr_pkg::REG_W-1:0] write_data
);
  import apr_pkg::*;

  localparam int SW = FRAC_BITS + 2;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic                   en;
  logic [TOTAL_LAT-1:0]   vld;
  logic signed [REG_W-1:0] tensor_xx, tensor_yy, tensor_zz;
  logic signed [REG_W-1:0] tensor_xy_sum, tensor_xz_sum, tensor_yz_sum;
  logic [23:0]            ra_w, de_w, psi_w;
  logic [ANGLE_BITS-1:0]  ra_a, ra_c, de_a, de_c, psi_a, psi2_a, psi2_c;
  logic signed [SW-1:0]   sin_ra, cos_ra, sin_dec, cos_dec, sin_psi, cos_psi;
  logic signed [SW-1:0]   cos_dly [CONTR_LAT];
  logic signed [SW-1:0]   sin_dly [CONTR_LAT];
  logic signed [OUT_W-1:0] u, v;

  // pipeline advance
  assign en              = !response.valid || response.ready;
  assign direction.ready = en;
  assign response.valid  = vld[TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL_LAT-2:0], direction.valid};
    end
  end

  // tensor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tensor_xx     <= '0;
      tensor_yy     <= '0;
      tensor_zz     <= '0;
      tensor_xy_sum <= '0;
      tensor_xz_sum <= '0;
      tensor_yz_sum <= '0;
    end else if (write_en) begin
      unique case (reg_idx_t'(write_index))
        REG_XX:  tensor_xx     <= write_data;
        REG_YY:  tensor_yy     <= write_data;
        REG_ZZ:  tensor_zz     <= write_data;
        REG_XY:  tensor_xy_sum <= write_data;
        REG_XZ:  tensor_xz_sum <= write_data;
        REG_YZ:  tensor_yz_sum <= write_data;
        default: ;
      endcase
    end
  end

  // input angles to the internal turn resolution
  always_comb begin
    ra_w   = {direction.right_ascension, 8'h00} >> (24 - ANGLE_BITS);
    de_w   = {direction.declination, 8'h00} >> (24 - ANGLE_BITS);
    psi_w  = {direction.pol_angle, 8'h00} >> (24 - ANGLE_BITS);
    ra_a   = ra_w[ANGLE_BITS-1:0];
    de_a   = de_w[ANGLE_BITS-1:0];
    psi_a  = psi_w[ANGLE_BITS-1:0];
    psi2_a = {psi_a[ANGLE_BITS-2:0], 1'b0};
    ra_c   = ra_a + QUARTER;
    de_c   = de_a + QUARTER;
    psi2_c = psi2_a + QUARTER;
  end

  // six sine pipelines, cosine by a quarter-turn offset
  apr_sin #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sin_ra (
    .clk(clk), .en(en), .angle(ra_a), .value(sin_ra));
  apr_sin #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cos_ra (
    .clk(clk), .en(en), .angle(ra_c), .value(cos_ra));
  apr_sin #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sin_dec (
    .clk(clk), .en(en), .angle(de_a), .value(sin_dec));
  apr_sin #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cos_dec (
    .clk(clk), .en(en), .angle(de_c), .value(cos_dec));
  apr_sin #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sin_psi (
    .clk(clk), .en(en), .angle(psi2_a), .value(sin_psi));
  apr_sin #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cos_psi (
    .clk(clk), .en(en), .angle(psi2_c), .value(cos_psi));

  // hold the rotation terms while the contraction runs
  always_ff @(posedge clk) begin
    if (en) begin
      cos_dly[0] <= cos_psi;
      sin_dly[0] <= sin_psi;
      for (int i = 1; i < CONTR_LAT; i++) begin
        cos_dly[i] <= cos_dly[i-1];
        sin_dly[i] <= sin_dly[i-1];
      end
    end
  end

  apr_contract #(.FRAC_BITS(FRAC_BITS)) u_contract (
    .clk          (clk),
    .en           (en),
    .sin_ra       (sin_ra),
    .cos_ra       (cos_ra),
    .sin_dec      (sin_dec),
    .cos_dec      (cos_dec),
    .tensor_xx    (tensor_xx),
    .tensor_yy    (tensor_yy),
    .tensor_zz    (tensor_zz),
    .tensor_xy_sum(tensor_xy_sum),
    .tensor_xz_sum(tensor_xz_sum),
    .tensor_yz_sum(tensor_yz_sum),
    .u            (u),
    .v            (v)
  );

  apr_rotate #(.FRAC_BITS(FRAC_BITS)) u_rotate (
    .clk     (clk),
    .en      (en),
    .cos_2psi(cos_dly[CONTR_LAT-1]),
    .sin_2psi(sin_dly[CONTR_LAT-1]),
    .u       (u),
    .v       (v),
    .f_plus  (response.plus_response),
    .f_cross (response.cross_response),
    .u_out   (response.plus_contraction),
    .v_out   (response.cross_contraction)
  );

  // checks
  `APR_CHECK_NEXT(a_stall_freezes_valid, clk, rst, !direction.ready, $stable(vld))
  `APR_CHECK_NOW(a_stall_blocks_input, clk, rst, response.valid && !response.ready, !direction.ready)
  `APR_CHECK_NEXT(a_bad_index_ignored, clk, rst, write_en && (write_index >= IDX_W'(NUM_REGS)), $stable(tensor_xx) && $stable(tensor_yz_sum))
  `APR_CHECK_NEXT(a_reset_empties, clk, 1'b0, rst, vld == '0)

endmodule

// File: design/apr_horner.sv
// ----------------------------------------------------------------------------
// apr_horner
// one horner step of the sine series: y = 1 - ((x2 * y) >> 30) / den
// ----------------------------------------------------------------------------
module apr_horner #(
  parameter logic [6:0]  DEN   = apr_pkg::HORNER_DEN[0],
  parameter logic [31:0] RECIP = apr_pkg::HORNER_RECIP[0]
) (
  input  logic           clk,
  input  logic           en,
  input  apr_pkg::kern_t din,
  output apr_pkg::kern_t dout
);
  import apr_pkg::*;

  logic [62:0] pprod;
  logic [31:0] pa;
  kern_t       ka;
  logic [63:0] qprod;
  logic [31:0] qe;
  logic [31:0] pb;
  kern_t       kb;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [30:0] y_next;

  // product with the running term
  assign pprod = 63'(din.x2) * 63'(din.y);

  // quotient estimate by reciprocal, low by at most one
  assign qprod = 64'(pa) * 64'(RECIP);

  // one correction, then subtract from one with floor at zero
  always_comb begin
    rem = pb - 32'(qe * 32'(DEN));
    quo = (rem >= 32'(DEN)) ? qe + 32'd1 : qe;
    y_next = (quo >= Q30_ONE) ? 31'd0 : 31'(Q30_ONE - quo);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa   <= pprod[61:30];
      ka   <= din;
      qe   <= qprod[63:32];
      pb   <= pa;
      kb   <= ka;
      dout <= '{x: kb.x, x2: kb.x2, y: y_next, neg: kb.neg};
    end
  end

endmodule

// File: design/apr_sin.sv
// ----------------------------------------------------------------------------
// apr_sin
// pipelined sine of a turn fraction, quarter-wave reduction and taylor series
// ----------------------------------------------------------------------------
module apr_sin #(
  parameter int ANGLE_BITS = apr_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = apr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ANGLE_BITS-1:0]       angle,
  output logic signed [FRAC_BITS+1:0] value
);
  import apr_pkg::*;

  localparam int RW = ANGLE_BITS - 1;
  localparam int SH = 30 - FRAC_BITS;
  localparam logic [RW-1:0] QUARTER = RW'(1) << (ANGLE_BITS - 2);
  localparam logic [31:0]   ONE_F   = 32'(1) << FRAC_BITS;

  logic [1:0]            quad;
  logic [RW-1:0]         red;
  logic [RW+31:0]        xprod;
  logic [30:0]           xa;
  logic                  nega;
  logic [61:0]           sqprod;
  kern_t                 chain [HORNER_STEPS+1];
  logic [61:0]           sprod;
  logic [30:0]           sf;
  logic                  negf;
  logic [31:0]           s_rnd;
  logic [FRAC_BITS:0]    mag;
  logic signed [FRAC_BITS+1:0] mag_s;

  // fold to the first quarter and scale to radians in q30
  always_comb begin
    quad  = angle[ANGLE_BITS-1:ANGLE_BITS-2];
    red   = quad[0] ? RW'(QUARTER - {1'b0, angle[ANGLE_BITS-3:0]})
                    : {1'b0, angle[ANGLE_BITS-3:0]};
    xprod = (RW+32)'(red) * (RW+32)'(TWO_PI_Q29);
  end

  assign sqprod = 62'(xa) * 62'(xa);

  always_ff @(posedge clk) begin
    if (en) begin
      xa       <= xprod[RW +: 31];
      nega     <= quad[1];
      chain[0] <= '{x: xa, x2: sqprod[61:30], y: Q30_ONE[30:0], neg: nega};
    end
  end

  // horner steps from the x^10 term down
  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_step
    apr_horner #(
      .DEN  (HORNER_DEN[k]),
      .RECIP(HORNER_RECIP[k])
    ) u_step (
      .clk (clk),
      .en  (en),
      .din (chain[k]),
      .dout(chain[k+1])
    );
  end

  assign sprod = 62'(chain[HORNER_STEPS].x) * 62'(chain[HORNER_STEPS].y);

  // round to the output fraction
  if (SH > 0) begin : g_rnd
    assign s_rnd = (32'(sf) + (32'(1) << (SH - 1))) >> SH;
  end else begin : g_nornd
    assign s_rnd = 32'(sf);
  end

  // cap at one and apply the half-wave sign
  always_comb begin
    mag   = (s_rnd > ONE_F) ? ONE_F[FRAC_BITS:0] : s_rnd[FRAC_BITS:0];
    mag_s = {1'b0, mag};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sf    <= sprod[60:30];
      negf  <= chain[HORNER_STEPS].neg;
      value <= negf ? -mag_s : mag_s;
    end
  end

endmodule

// File: design/apr_contract.sv
// ----------------------------------------------------------------------------
// apr_contract
// wave-frame vectors, plus and cross basis tensors and their contraction
// with the detector tensor
// ----------------------------------------------------------------------------
module apr_contract #(
  parameter int FRAC_BITS = apr_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [FRAC_BITS+1:0]        sin_ra,
  input  logic signed [FRAC_BITS+1:0]        cos_ra,
  input  logic signed [FRAC_BITS+1:0]        sin_dec,
  input  logic signed [FRAC_BITS+1:0]        cos_dec,
  input  logic signed [apr_pkg::REG_W-1:0]   tensor_xx,
  input  logic signed [apr_pkg::REG_W-1:0]   tensor_yy,
  input  logic signed [apr_pkg::REG_W-1:0]   tensor_zz,
  input  logic signed [apr_pkg::REG_W-1:0]   tensor_xy_sum,
  input  logic signed [apr_pkg::REG_W-1:0]   tensor_xz_sum,
  input  logic signed [apr_pkg::REG_W-1:0]   tensor_yz_sum,
  output logic signed [apr_pkg::OUT_W-1:0]   u,
  output logic signed [apr_pkg::OUT_W-1:0]   v
);
  import apr_pkg::*;

  localparam int SW = FRAC_BITS + 2;
  localparam int PW = 2 * SW + 1;
  localparam int EW = FRAC_BITS + 3;
  localparam int CW = EW + REG_W;
  localparam int AW = CW + 3;
  localparam logic signed [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [AW-1:0] HALF_A = AW'(1) << (FRAC_BITS - 1);

  function automatic logic signed [PW-1:0] rnd_p(input logic signed [PW-1:0] a);
    return (a + HALF_P) >>> FRAC_BITS;
  endfunction

  logic signed [PW-1:0] m_cs, m_ss;
  logic signed [SW-1:0] x0, x1, y0, y1, y2;
  logic signed [PW-1:0] w_y0, w_y1;
  logic signed [PW-1:0] xx0, yy0, xx1, yy1, yy2, x0x1, y0y1, y0y2, y1y2;
  logic signed [PW-1:0] x0y0, x1y1, x0y1, y0x1, x0y2, x1y2;
  logic signed [PW-1:0] r_pxx, r_pyy, r_pzz, r_pxy, r_pxz, r_pyz;
  logic signed [PW-1:0] r_cxx, r_cyy, r_cxy, r_cxz, r_cyz;
  logic signed [EW-1:0] pxx, pyy, pzz, pxy, pxz, pyz, cxx, cyy, cxy, cxz, cyz;
  logic signed [CW-1:0] t_pxx, t_pyy, t_pzz, t_pxy, t_pxz, t_pyz;
  logic signed [CW-1:0] t_cxx, t_cyy, t_cxy, t_cxz, t_cyz;
  logic signed [AW-1:0] u_sum, v_sum;
  logic signed [AW-1:0] u_rnd, v_rnd;
  logic signed [63:0]   u_ext, v_ext;

  // wave-frame vectors
  always_comb begin
    m_cs = cos_ra * sin_dec;
    m_ss = sin_ra * sin_dec;
    w_y0 = rnd_p(-m_cs);
    w_y1 = rnd_p(-m_ss);
  end

  // basis tensor entries
  always_comb begin
    r_pxx = rnd_p(xx0 - yy0);
    r_pyy = rnd_p(xx1 - yy1);
    r_pzz = rnd_p(-yy2);
    r_pxy = rnd_p(x0x1 - y0y1);
    r_pxz = rnd_p(-y0y2);
    r_pyz = rnd_p(-y1y2);
    r_cxx = rnd_p(x0y0 <<< 1);
    r_cyy = rnd_p(x1y1 <<< 1);
    r_cxy = rnd_p(x0y1 + y0x1);
    r_cxz = rnd_p(x0y2);
    r_cyz = rnd_p(x1y2);
  end

  // contraction round and clamp
  always_comb begin
    u_rnd = (u_sum + HALF_A) >>> FRAC_BITS;
    v_rnd = (v_sum + HALF_A) >>> FRAC_BITS;
    u_ext = u_rnd;
    v_ext = v_rnd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // vectors
      x0 <= sin_ra;
      x1 <= -cos_ra;
      y0 <= w_y0[SW-1:0];
      y1 <= w_y1[SW-1:0];
      y2 <= cos_dec;
      // outer products
      xx0  <= x0 * x0;
      yy0  <= y0 * y0;
      xx1  <= x1 * x1;
      yy1  <= y1 * y1;
      yy2  <= y2 * y2;
      x0x1 <= x0 * x1;
      y0y1 <= y0 * y1;
      y0y2 <= y0 * y2;
      y1y2 <= y1 * y2;
      x0y0 <= x0 * y0;
      x1y1 <= x1 * y1;
      x0y1 <= x0 * y1;
      y0x1 <= y0 * x1;
      x0y2 <= x0 * y2;
      x1y2 <= x1 * y2;
      // tensor entries
      pxx <= r_pxx[EW-1:0];
      pyy <= r_pyy[EW-1:0];
      pzz <= r_pzz[EW-1:0];
      pxy <= r_pxy[EW-1:0];
      pxz <= r_pxz[EW-1:0];
      pyz <= r_pyz[EW-1:0];
      cxx <= r_cxx[EW-1:0];
      cyy <= r_cyy[EW-1:0];
      cxy <= r_cxy[EW-1:0];
      cxz <= r_cxz[EW-1:0];
      cyz <= r_cyz[EW-1:0];
      // weighted entries
      t_pxx <= tensor_xx * pxx;
      t_pyy <= tensor_yy * pyy;
      t_pzz <= tensor_zz * pzz;
      t_pxy <= tensor_xy_sum * pxy;
      t_pxz <= tensor_xz_sum * pxz;
      t_pyz <= tensor_yz_sum * pyz;
      t_cxx <= tensor_xx * cxx;
      t_cyy <= tensor_yy * cyy;
      t_cxy <= tensor_xy_sum * cxy;
      t_cxz <= tensor_xz_sum * cxz;
      t_cyz <= tensor_yz_sum * cyz;
      // sums
      u_sum <= AW'(t_pxx) + AW'(t_pyy) + AW'(t_pzz) + AW'(t_pxy) + AW'(t_pxz)
             + AW'(t_pyz);
      v_sum <= AW'(t_cxx) + AW'(t_cyy) + AW'(t_cxy) + AW'(t_cxz) + AW'(t_cyz);
      // q2.16 results
      u <= sat_out(u_ext);
      v <= sat_out(v_ext);
    end
  end

endmodule

// File: design/apr_rotate.sv
// ----------------------------------------------------------------------------
// apr_rotate
// rotation of the contraction pair by twice the polarization angle
// ----------------------------------------------------------------------------
module apr_rotate #(
  parameter int FRAC_BITS = apr_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [FRAC_BITS+1:0]      cos_2psi,
  input  logic signed [FRAC_BITS+1:0]      sin_2psi,
  input  logic signed [apr_pkg::OUT_W-1:0] u,
  input  logic signed [apr_pkg::OUT_W-1:0] v,
  output logic signed [apr_pkg::OUT_W-1:0] f_plus,
  output logic signed [apr_pkg::OUT_W-1:0] f_cross,
  output logic signed [apr_pkg::OUT_W-1:0] u_out,
  output logic signed [apr_pkg::OUT_W-1:0] v_out
);
  import apr_pkg::*;

  localparam int MW = FRAC_BITS + 2 + OUT_W;
  localparam int SW = MW + 1;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

  logic signed [MW-1:0]    cu, sv, cv, su;
  logic signed [SW-1:0]    sum_p, sum_c;
  logic signed [SW-1:0]    rnd_p, rnd_c;
  logic signed [63:0]      ext_p, ext_c;
  logic signed [OUT_W-1:0] u_d1, v_d1, u_d2, v_d2;

  always_comb begin
    rnd_p = (sum_p + HALF) >>> FRAC_BITS;
    rnd_c = (sum_c + HALF) >>> FRAC_BITS;
    ext_p = rnd_p;
    ext_c = rnd_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products
      cu   <= cos_2psi * u;
      sv   <= sin_2psi * v;
      cv   <= cos_2psi * v;
      su   <= sin_2psi * u;
      u_d1 <= u;
      v_d1 <= v;
      // sums
      sum_p <= SW'(cu) + SW'(sv);
      sum_c <= SW'(cv) - SW'(su);
      u_d2  <= u_d1;
      v_d2  <= v_d1;
      // round and clamp
      f_plus  <= sat_out(ext_p);
      f_cross <= sat_out(ext_c);
      u_out   <= u_d2;
      v_out   <= v_d2;
    end
  end

endmodule

// File: tb/sv/antenna_pattern_response_core_test.sv
// ----------------------------------------------------------------------------
// antenna_pattern_response_core_test
// drives sky directions and polarization angles through the core under several
// detector tensors, predicts plus/cross responses in fixed point and compares
// every response item field by field, with random stalls on both channels
// ----------------------------------------------------------------------------
module antenna_pattern_response_core_test;
  import apr_pkg::*;

  localparam logic [IDX_W-1:0] UNUSED_INDEX = 3'd7;
  localparam int PIPE_DEPTH = 28;

  typedef struct {
    logic signed [OUT_W-1:0] plus_resp;
    logic signed [OUT_W-1:0] cross_resp;
    logic signed [OUT_W-1:0] plus_contr;
    logic signed [OUT_W-1:0] cross_contr;
  } antenna_resp_t;

  // antenna response scoreboard with its own fixed-point model of the core
  class antenna_scoreboard;
    longint tensor [NUM_REGS];
    antenna_resp_t pending_resp [$];
    int errors;

    function new();
      foreach (tensor[i]) tensor[i] = 0;
      errors = 0;
    endfunction

    function void load_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
      if (idx < NUM_REGS) tensor[idx] = longint'($signed(data));
    endfunction

    // sine of x in [0, pi/2], unsigned q30 horner taylor series
    function automatic longint unsigned taylor_sin(longint unsigned x);
      longint unsigned den [5] = '{110, 72, 42, 20, 6};
      longint unsigned x2, y, t;
      x2 = (x * x) >> 30;
      y = 64'd1 << 30;
      for (int k = 0; k < 5; k++) begin
        t = ((x2 * y) >> 30) / den[k];
        y = (t >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
      end
      return (x * y) >> 30;
    endfunction

    function automatic longint turn_sine(logic [15:0] a);
      longint unsigned rr, s;
      rr = a[14] ? 64'd16384 - a[13:0] : 64'(a[13:0]);
      s = taylor_sin((rr * 64'd3373259426) >> 15);
      s = (s + (64'd1 << 13)) >> 14;
      if (s > 64'd65536) s = 64'd65536;
      return a[15] ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint turn_cosine(logic [15:0] a);
      logic [15:0] b;
      b = a + 16'h4000;
      return turn_sine(b);
    endfunction

    // round half up toward +inf after dropping 16 fraction bits
    function automatic longint q16_round(longint v);
      return (v + 32768) >>> 16;
    endfunction

    function automatic longint clamp18(longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
    endfunction

    // accepted direction item: compute its response
    function void note_direction(logic [15:0] ra, logic [15:0] dec, logic [15:0] pol);
      longint sa, ca, sd, cd, x0, x1, y0, y1, y2;
      longint pxx, pyy, pzz, pxy, pxz, pyz, cxx, cyy, cxy, cxz, cyz;
      longint u, v, c2, s2;
      logic [15:0] psi2;
      antenna_resp_t r;
      sa = turn_sine(ra);
      ca = turn_cosine(ra);
      sd = turn_sine(dec);
      cd = turn_cosine(dec);
      x0 = sa;
      x1 = -ca;
      y0 = q16_round(-ca * sd);
      y1 = q16_round(-sa * sd);
      y2 = cd;
      pxx = q16_round(x0 * x0 - y0 * y0);
      pyy = q16_round(x1 * x1 - y1 * y1);
      pzz = q16_round(-y2 * y2);
      pxy = q16_round(x0 * x1 - y0 * y1);
      pxz = q16_round(-y0 * y2);
      pyz = q16_round(-y1 * y2);
      cxx = q16_round(2 * x0 * y0);
      cyy = q16_round(2 * x1 * y1);
      cxy = q16_round(x0 * y1 + y0 * x1);
      cxz = q16_round(x0 * y2);
      cyz = q16_round(x1 * y2);
      u = tensor[REG_XX] * pxx + tensor[REG_YY] * pyy + tensor[REG_ZZ] * pzz
        + tensor[REG_XY] * pxy + tensor[REG_XZ] * pxz + tensor[REG_YZ] * pyz;
      v = tensor[REG_XX] * cxx + tensor[REG_YY] * cyy
        + tensor[REG_XY] * cxy + tensor[REG_XZ] * cxz + tensor[REG_YZ] * cyz;
      u = clamp18(q16_round(u));
      v = clamp18(q16_round(v));
      psi2 = {pol[14:0], 1'b0};
      c2 = turn_cosine(psi2);
      s2 = turn_sine(psi2);
      r.plus_resp   = OUT_W'(clamp18(q16_round(c2 * u + s2 * v)));
      r.cross_resp  = OUT_W'(clamp18(q16_round(c2 * v - s2 * u)));
      r.plus_contr  = OUT_W'(u);
      r.cross_contr = OUT_W'(v);
      pending_resp.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [OUT_W-1:0] exp_v,
                                logic signed [OUT_W-1:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_response(antenna_resp_t act);
      antenna_resp_t exp_r;
      if (pending_resp.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none actual %0d %0d %0d %0d", $time,
                 act.plus_resp, act.cross_resp, act.plus_contr, act.cross_contr);
      end else begin
        exp_r = pending_resp.pop_front();
        compare_field("plus_response", exp_r.plus_resp, act.plus_resp);
        compare_field("cross_response", exp_r.cross_resp, act.cross_resp);
        compare_field("plus_contraction", exp_r.plus_contr, act.plus_contr);
        compare_field("cross_contraction", exp_r.cross_contr, act.cross_contr);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_en = 1'b0;
  logic [IDX_W-1:0] write_index = '0;
  logic [REG_W-1:0] write_data = '0;

  apr_in_if direction_ch();
  apr_out_if response_ch();

  antenna_pattern_response_core DUT (
    .clk(clk),
    .rst(rst),
    .direction(direction_ch),
    .response(response_ch),
    .write_en(write_en),
    .write_index(write_index),
    .write_data(write_data)
  );

  antenna_scoreboard scoreboard = new();
  bit quiet = 1'b0;
  int hold_request = 0;

  always #5 clk = ~clk;

  initial begin
    direction_ch.valid = 1'b0;
    direction_ch.right_ascension = '0;
    direction_ch.declination = '0;
    direction_ch.pol_angle = '0;
    response_ch.ready = 1'b0;
  end

  // response side: random stall bursts, one long hold-off on request, checking
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    antenna_resp_t act;
    if (!rst && response_ch.valid && response_ch.ready) begin
      act.plus_resp   = response_ch.plus_response;
      act.cross_resp  = response_ch.cross_response;
      act.plus_contr  = response_ch.plus_contraction;
      act.cross_contr = response_ch.cross_contraction;
      scoreboard.check_response(act);
    end
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      response_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      response_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      response_ch.ready <= 1'b0;
    end else begin
      response_ch.ready <= 1'b1;
    end
  end

  // offer one direction item, with an optional idle burst in front
  task automatic send_direction(logic [15:0] ra, logic [15:0] dec, logic [15:0] pol);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      direction_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    direction_ch.valid <= 1'b1;
    direction_ch.right_ascension <= ra;
    direction_ch.declination <= dec;
    direction_ch.pol_angle <= pol;
    do @(posedge clk); while (!direction_ch.ready);
    scoreboard.note_direction(ra, dec, pol);
  endtask

  task automatic send_random(int count);
    logic [15:0] dec;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 7) == 0) dec = 16'($urandom);
      else dec = 16'($urandom_range(0, 32768) - 16384);
      send_direction(16'($urandom), dec, 16'($urandom));
    end
  endtask

  // wait for the pipeline to drain before touching the tensor
  task automatic drain();
    direction_ch.valid <= 1'b0;
    while (scoreboard.pending_resp.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic load_tensor(longint vals [NUM_REGS]);
    reg_idx_t idx;
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = reg_idx_t'(i);
      write_en <= 1'b1;
      write_index <= idx;
      write_data <= REG_W'(vals[i]);
      @(posedge clk);
      scoreboard.load_reg(idx, REG_W'(vals[i]));
    end
    // a write to an index past the register file must change nothing
    write_index <= UNUSED_INDEX;
    write_data <= REG_W'(-1);
    @(posedge clk);
    scoreboard.load_reg(UNUSED_INDEX, REG_W'(-1));
    write_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_directed();
    logic [15:0] ra_set [5] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
    logic [15:0] dec_set [5] = '{16'hC000, 16'h0000, 16'h4000, 16'h8000, 16'h7FFF};
    logic [15:0] pol_set [5] = '{16'h0000, 16'h2000, 16'h4000, 16'hFFFF, 16'h8000};
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++)
        send_direction(ra_set[i], dec_set[(i + j) % 5], pol_set[(i * 2 + j) % 5]);
  endtask

  // main sequence over tensor settings
  initial begin
    longint det [NUM_REGS];
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset tensor of zeros
    send_random(40);
    drain();

    // realistic detector: diagonal plus mixed terms
    det = '{-25000, 22000, 3000, -40000, 15000, -9000};
    load_tensor(det);
    send_directed();
    send_random(90);
    drain();

    // all at the positive extreme, saturates the outputs
    det = '{131071, 131071, 131071, 131071, 131071, 131071};
    load_tensor(det);
    send_directed();
    send_random(80);
    drain();

    // all at the negative extreme, with a long receiver hold-off
    det = '{-131072, -131072, -131072, -131072, -131072, -131072};
    load_tensor(det);
    hold_request = 300;
    send_random(100);
    drain();

    // alternating signs
    det = '{131071, -131072, 65536, -65536, 131071, -131072};
    load_tensor(det);
    send_random(80);
    drain();

    // random tensors, the last without idling
    for (int p = 0; p < 3; p++) begin
      foreach (det[i]) det[i] = longint'($urandom_range(0, 262143)) - 131072;
      load_tensor(det);
      if (p == 2) quiet = 1'b1;
      send_random(80);
      drain();
    end

    if (scoreboard.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: antenna_pattern_response_core.f
+incdir+design
design/apr_pkg.sv
design/apr_in_if.sv
design/apr_out_if.sv
design/apr_horner.sv
design/apr_sin.sv
design/apr_contract.sv
design/apr_rotate.sv
design/antenna_pattern_response_core.sv
tb/sv/antenna_pattern_response_core_test.sv
